// ----- design/spt_pkg.sv -----
// spt_pkg: shared constants and types of the segment pose transform
// angle units, radian conversion constants and the series divisors
// no dependencies
package spt_pkg;

	// heading units: 1/128 degree
	localparam logic [15:0] FULL_TURN          = 16'd46080;
	localparam logic [15:0] THREE_QUARTER_TURN = 16'd34560;
	localparam logic [15:0] HALF_TURN          = 16'd23040;
	localparam logic [15:0] QUARTER_TURN       = 16'd11520;
	localparam logic [15:0] EIGHTH_TURN        = 16'd5760;

	// octant angle u to radians in q30: round(u * 3.14159265 / 180 / 128 * 2^30)
	// split as u * RAD_WHOLE + floor((u * RAD_FRAC + RAD_BIAS) / RAD_DIV)
	localparam logic [17:0] RAD_WHOLE = 18'd146408;
	localparam logic [18:0] RAD_FRAC  = 19'd323864;
	localparam logic [17:0] RAD_BIAS  = 18'd195312;
	localparam logic [18:0] RAD_DIV   = 19'd390625;
	localparam logic [12:0] RAD_RECIP = 13'((64'd1 << 31) / 64'(RAD_DIV));

	// q30 fixed point one and half
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [30:0] Q30_HALF = 31'h2000_0000;

	// nested taylor series divisors, innermost term first
	localparam int SIN_STEPS = 5;
	localparam int COS_STEPS = 6;
	typedef logic [7:0] series_div_t;
	localparam series_div_t SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam series_div_t COS_DIV [COS_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

	// register stages from heading to sine and cosine
	localparam int TRIG_LATENCY = 26;

	// quadrant of the reduced heading
	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

endpackage

// ----- design/spt_if.sv -----
// spt_if: valid/ready channels of the segment pose transform
// spt_seg_if carries a local segment request, spt_pose_if a global result
// no dependencies
interface spt_seg_if #(parameter int COORD_WIDTH = 24);
	logic                          valid;
	logic                          ready;
	logic signed [16:0]            heading;
	logic [19:0]                   distance;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;
	logic [15:0]                   object_tag;
	logic [15:0]                   group_tag;
	logic                          view_end_in;

	modport source (
		output valid, heading, distance, start_x, start_y, end_x, end_y,
		output object_tag, group_tag, view_end_in,
		input  ready
	);
	modport sink (
		input  valid, heading, distance, start_x, start_y, end_x, end_y,
		input  object_tag, group_tag, view_end_in,
		output ready
	);
endinterface

interface spt_pose_if #(parameter int COORD_WIDTH = 24);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] global_start_x;
	logic signed [COORD_WIDTH-1:0] global_start_y;
	logic signed [COORD_WIDTH-1:0] global_end_x;
	logic signed [COORD_WIDTH-1:0] global_end_y;
	logic [15:0]                   object_tag_out;
	logic [15:0]                   group_tag_out;
	logic                          view_end_out;

	modport source (
		output valid, global_start_x, global_start_y, global_end_x, global_end_y,
		output object_tag_out, group_tag_out, view_end_out,
		input  ready
	);
	modport sink (
		input  valid, global_start_x, global_start_y, global_end_x, global_end_y,
		input  object_tag_out, group_tag_out, view_end_out,
		output ready
	);
endinterface

// ----- design/spt_series_step.sv -----
// spt_series_step: one nested taylor step, t_out = 1 - round(x2 * t / K) in q30
// three register stages: multiply, reciprocal multiply, correction
// depends on spt_pkg
module spt_series_step #(
	parameter logic [7:0] K = 8'd2
) (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] x2,
	input  logic [30:0] t,
	output logic [30:0] t_out
);
	import spt_pkg::*;

	// rounding bias K * 2^29 and floor(2^31 / K)
	localparam logic [60:0] RND   = 61'(K) << 29;
	localparam logic [30:0] RECIP = 31'((62'd1 << 31) / 62'(K));

	logic [60:0] acc_s1;
	logic [30:0] n_s2;
	logic [61:0] qm_s2;
	logic [30:0] t_s3;
	logic [30:0] q0;
	logic [30:0] rem;

	// estimate quotient is exact or one low; one compare fixes it
	always_comb begin
		q0  = qm_s2[61:31];
		rem = n_s2 - q0 * 31'(K);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1 <= 61'(x2) * 61'(t) + RND;
			n_s2   <= acc_s1[60:30];
			qm_s2  <= 62'(acc_s1[60:30]) * 62'(RECIP);
			t_s3   <= Q30_ONE - q0 - 31'(rem >= 31'(K));
		end
	end

	assign t_out = t_s3;
endmodule

// ----- design/spt_trig.sv -----
// spt_trig: pipelined sine and cosine of a heading in 1/128 degree
// octant reduction, radian conversion, nested taylor series, quadrant fold
// depends on spt_pkg and spt_series_step
module spt_trig #(
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [16:0]             heading,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);
	import spt_pkg::*;

	localparam int F  = TRIG_FRAC_BITS;
	localparam int TW = F + 2;
	localparam int SH = 30 - F;
	localparam logic [30:0] SH_HALF = 31'd1 << (SH - 1);

	localparam logic signed [17:0] TURN_S   = signed'(18'(FULL_TURN));
	localparam logic signed [17:0] TURN2_S  = signed'(18'(FULL_TURN) << 1);

	typedef struct packed {
		quad_t quad;
		logic  swap;
	} oct_t;

	logic signed [17:0] hx;
	logic signed [17:0] a_red;
	logic [15:0]        a_s1;
	logic [13:0]        r_rem;
	oct_t               oct_nx;
	logic [12:0]        u_nx;
	logic [12:0]        u_s2;
	oct_t               oct_s [2:25];
	logic [29:0]        hi_s3;
	logic [30:0]        nlo_s3;
	logic [29:0]        hi_s4;
	logic [30:0]        nlo_s4;
	logic [43:0]        qm_s4;
	logic [12:0]        rq0;
	logic [30:0]        rrem;
	logic [29:0]        x_s5;
	logic [29:0]        x_s6;
	logic [59:0]        xx_s6;
	logic [59:0]        xx_rnd;
	logic [29:0]        x_s [7:22];
	logic [29:0]        x2_s [7:22];
	logic [30:0]        ct [0:COS_STEPS];
	logic [30:0]        st [0:SIN_STEPS];
	logic [60:0]        sp_s23;
	logic [30:0]        s_sum;
	logic [F:0]         so_s24;
	logic [F:0]         so_s25;
	logic [30:0]        c_sum;
	logic [F:0]         c_oct;
	logic signed [TW-1:0] s0;
	logic signed [TW-1:0] c0;
	logic signed [TW-1:0] sin_s26;
	logic signed [TW-1:0] cos_s26;

	// heading modulo one full turn
	always_comb begin
		hx = 18'(heading);
		if (hx >= TURN_S) begin
			a_red = hx - TURN_S;
		end else if (hx >= 18'sd0) begin
			a_red = hx;
		end else if (hx >= -TURN_S) begin
			a_red = hx + TURN_S;
		end else begin
			a_red = hx + TURN2_S;
		end
	end

	// quadrant, remainder and first-octant fold
	always_comb begin
		if (a_s1 >= THREE_QUARTER_TURN) begin
			oct_nx.quad = QUAD_IV;
			r_rem = 14'(a_s1 - THREE_QUARTER_TURN);
		end else if (a_s1 >= HALF_TURN) begin
			oct_nx.quad = QUAD_III;
			r_rem = 14'(a_s1 - HALF_TURN);
		end else if (a_s1 >= QUARTER_TURN) begin
			oct_nx.quad = QUAD_II;
			r_rem = 14'(a_s1 - QUARTER_TURN);
		end else begin
			oct_nx.quad = QUAD_I;
			r_rem = 14'(a_s1);
		end
		oct_nx.swap = (16'(r_rem) > EIGHTH_TURN);
		if (oct_nx.swap) begin
			u_nx = 13'(QUARTER_TURN - 16'(r_rem));
		end else begin
			u_nx = 13'(r_rem);
		end
	end

	// radian conversion correction step
	always_comb begin
		rq0  = qm_s4[43:31];
		rrem = nlo_s4 - 31'(rq0) * 31'(RAD_DIV);
	end

	assign xx_rnd = xx_s6 + 60'(Q30_HALF);

	// front stages: reduction, radians, square
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1      <= a_red[15:0];
			u_s2      <= u_nx;
			oct_s[2]  <= oct_nx;
			hi_s3     <= 30'(RAD_WHOLE) * 30'(u_s2);
			nlo_s3    <= 31'(u_s2) * 31'(RAD_FRAC) + 31'(RAD_BIAS);
			hi_s4     <= hi_s3;
			nlo_s4    <= nlo_s3;
			qm_s4     <= 44'(nlo_s3) * 44'(RAD_RECIP);
			x_s5      <= hi_s4 + 30'(rq0) + 30'(rrem >= 31'(RAD_DIV));
			x_s6      <= x_s5;
			xx_s6     <= 60'(x_s5) * 60'(x_s5);
			x_s[7]    <= x_s6;
			x2_s[7]   <= xx_rnd[59:30];
			for (int k = 3; k <= 25; k++) begin
				oct_s[k] <= oct_s[k-1];
			end
			for (int k = 8; k <= 22; k++) begin
				x_s[k]  <= x_s[k-1];
				x2_s[k] <= x2_s[k-1];
			end
		end
	end

	// series chains, one step every three stages
	assign ct[0] = Q30_ONE;
	assign st[0] = Q30_ONE;

	for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
		spt_series_step #(.K(COS_DIV[i])) u_cos_step (
			.clk   (clk),
			.en    (en),
			.x2    (x2_s[7 + 3*i]),
			.t     (ct[i]),
			.t_out (ct[i+1])
		);
	end

	for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
		spt_series_step #(.K(SIN_DIV[i])) u_sin_step (
			.clk   (clk),
			.en    (en),
			.x2    (x2_s[7 + 3*i]),
			.t     (st[i]),
			.t_out (st[i+1])
		);
	end

	// sine = x * series, rounded to trig fraction bits
	assign s_sum = sp_s23[60:30] + SH_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s23 <= 61'(x_s[22]) * 61'(st[SIN_STEPS]) + 61'(Q30_HALF);
			so_s24 <= s_sum[30:SH];
			so_s25 <= so_s24;
		end
	end

	// cosine rounding, octant swap and quadrant signs
	always_comb begin
		c_sum = ct[COS_STEPS] + SH_HALF;
		c_oct = c_sum[30:SH];
		if (oct_s[25].swap) begin
			s0 = signed'({1'b0, c_oct});
			c0 = signed'({1'b0, so_s25});
		end else begin
			s0 = signed'({1'b0, so_s25});
			c0 = signed'({1'b0, c_oct});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (oct_s[25].quad)
				QUAD_I: begin
					sin_s26 <= s0;
					cos_s26 <= c0;
				end
				QUAD_II: begin
					sin_s26 <= c0;
					cos_s26 <= -s0;
				end
				QUAD_III: begin
					sin_s26 <= -s0;
					cos_s26 <= -c0;
				end
				default: begin
					sin_s26 <= -c0;
					cos_s26 <= s0;
				end
			endcase
		end
	end

	assign sin_val = sin_s26;
	assign cos_val = cos_s26;
endmodule

// ----- design/segment_pose_transform.sv -----
// segment_pose_transform: local view segment to global frame, pipelined
// takes one segment request per cycle while local_seg.ready is high, rotates it by the heading and adds the pose
// depends on spt_pkg, spt_if and spt_trig
//
// usage
//   local_seg  : valid/ready request with heading, distance, both endpoints,
//                object and group tags and the end-of-view mark
//   global_seg : valid/ready result with both endpoints in the global frame,
//                rounded half up to whole millimetres and saturated, tags copied
//   throughput : one segment per cycle while global_seg takes results
//   pipeline   : 26 stages of sine/cosine (six nested series steps of three
//                stages each), three stages of products, sums and rounding,
//                then the output register that drives global_seg
//   stalls     : the pipeline moves as one; an output register with a skid
//                entry behind it lets one more result drain after global_seg
//                stops, after which local_seg.ready drops until the skid empties
//   reset      : arst_n clears all valid bits; no result is lost or repeated
module segment_pose_transform #(
	parameter int COORD_WIDTH    = 24,
	parameter int TRIG_FRAC_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	spt_seg_if.sink    local_seg,
	spt_pose_if.source global_seg
);
	import spt_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int F     = TRIG_FRAC_BITS;
	localparam int TW    = F + 2;
	localparam int PW    = ((CW > 21) ? CW : 21) + F + 2;
	localparam int SW    = PW + 2;
	localparam int LAST  = TRIG_LATENCY + 3;

	localparam logic signed [SW-1:0] HALF_MM   = SW'(1) << (F - 1);
	localparam logic signed [SW-1:0] COORD_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] COORD_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [15:0] object_tag;
		logic [15:0] group_tag;
		logic        view_end;
	} tag_t;

	typedef struct packed {
		logic [19:0]          distance;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		tag_t                 tags;
	} seg_t;

	typedef struct packed {
		logic signed [CW-1:0] global_start_x;
		logic signed [CW-1:0] global_start_y;
		logic signed [CW-1:0] global_end_x;
		logic signed [CW-1:0] global_end_y;
		tag_t                 tags;
	} res_t;

	// round half up to whole millimetres, then clamp to the coordinate range
	function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		r = (v + HALF_MM) >>> F;
		if (r > COORD_MAX) begin
			return COORD_MAX[CW-1:0];
		end else if (r < COORD_MIN) begin
			return COORD_MIN[CW-1:0];
		end
		return r[CW-1:0];
	endfunction

	logic                 pipe_en;
	seg_t                 in_item;
	logic                 valid_s [1:LAST];
	seg_t                 item_s [1:TRIG_LATENCY];
	logic signed [TW-1:0] sin_val;
	logic signed [TW-1:0] cos_val;
	logic signed [20:0]   dist_sg;
	logic signed [PW-1:0] sxc_s27, sys_s27, sxs_s27, syc_s27;
	logic signed [PW-1:0] exc_s27, eys_s27, exs_s27, eyc_s27;
	logic signed [PW-1:0] ds_s27, dc_s27;
	tag_t                 tags_s27, tags_s28;
	logic signed [SW-1:0] gsx_s28, gsy_s28, gex_s28, gey_s28;
	res_t                 res_s29;
	res_t                 out_q;
	res_t                 skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;

	// pipeline advances whenever the skid entry is free
	assign pipe_en         = ~skid_valid_q;
	assign local_seg.ready = pipe_en;

	// request fields into one record
	always_comb begin
		in_item.distance        = local_seg.distance;
		in_item.start_x         = local_seg.start_x;
		in_item.start_y         = local_seg.start_y;
		in_item.end_x           = local_seg.end_x;
		in_item.end_y           = local_seg.end_y;
		in_item.tags.object_tag = local_seg.object_tag;
		in_item.tags.group_tag  = local_seg.group_tag;
		in_item.tags.view_end   = local_seg.view_end_in;
	end

	// sine and cosine of the heading
	spt_trig #(.TRIG_FRAC_BITS(F)) u_trig (
		.clk     (clk),
		.en      (pipe_en),
		.heading (local_seg.heading),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (pipe_en) begin
			valid_s[1] <= local_seg.valid;
			for (int k = 2; k <= LAST; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// payload line alongside the trig pipeline
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			item_s[1] <= in_item;
			for (int k = 2; k <= TRIG_LATENCY; k++) begin
				item_s[k] <= item_s[k-1];
			end
		end
	end

	assign dist_sg = signed'({1'b0, item_s[TRIG_LATENCY].distance});

	// products, sums of rotation and pose terms, rounding
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sxc_s27  <= PW'(item_s[TRIG_LATENCY].start_x) * PW'(cos_val);
			sys_s27  <= PW'(item_s[TRIG_LATENCY].start_y) * PW'(sin_val);
			sxs_s27  <= PW'(item_s[TRIG_LATENCY].start_x) * PW'(sin_val);
			syc_s27  <= PW'(item_s[TRIG_LATENCY].start_y) * PW'(cos_val);
			exc_s27  <= PW'(item_s[TRIG_LATENCY].end_x) * PW'(cos_val);
			eys_s27  <= PW'(item_s[TRIG_LATENCY].end_y) * PW'(sin_val);
			exs_s27  <= PW'(item_s[TRIG_LATENCY].end_x) * PW'(sin_val);
			eyc_s27  <= PW'(item_s[TRIG_LATENCY].end_y) * PW'(cos_val);
			ds_s27   <= PW'(dist_sg) * PW'(sin_val);
			dc_s27   <= PW'(dist_sg) * PW'(cos_val);
			tags_s27 <= item_s[TRIG_LATENCY].tags;

			// pose is (-d sin, d cos)
			gsx_s28  <= SW'(sxc_s27) - SW'(sys_s27) - SW'(ds_s27);
			gsy_s28  <= SW'(sxs_s27) + SW'(syc_s27) + SW'(dc_s27);
			gex_s28  <= SW'(exc_s27) - SW'(eys_s27) - SW'(ds_s27);
			gey_s28  <= SW'(exs_s27) + SW'(eyc_s27) + SW'(dc_s27);
			tags_s28 <= tags_s27;

			res_s29.global_start_x <= round_sat(gsx_s28);
			res_s29.global_start_y <= round_sat(gsy_s28);
			res_s29.global_end_x   <= round_sat(gex_s28);
			res_s29.global_end_y   <= round_sat(gey_s28);
			res_s29.tags           <= tags_s28;
		end
	end

	// output register with skid entry: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || global_seg.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= valid_s[LAST];
			end
		end else if (pipe_en && valid_s[LAST]) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output register with skid entry: data
	always_ff @(posedge clk) begin
		if (!out_valid_q || global_seg.ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else begin
				out_q <= res_s29;
			end
		end else if (pipe_en && valid_s[LAST]) begin
			skid_q <= res_s29;
		end
	end

	assign global_seg.valid          = out_valid_q;
	assign global_seg.global_start_x = out_q.global_start_x;
	assign global_seg.global_start_y = out_q.global_start_y;
	assign global_seg.global_end_x   = out_q.global_end_x;
	assign global_seg.global_end_y   = out_q.global_end_y;
	assign global_seg.object_tag_out = out_q.tags.object_tag;
	assign global_seg.group_tag_out  = out_q.tags.group_tag;
	assign global_seg.view_end_out   = out_q.tags.view_end;
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for segment_pose_transform, directed table then random segments
// depends on spt_pkg, spt_if (spt_seg_if, spt_pose_if) and the segment_pose_transform rtl
module tb;

	localparam int CW = 24;
	localparam int TF = 16;

	// run shape
	localparam int N_RANDOM    = 1930;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_AT    = 800;
	localparam int QUIET_TAIL  = 200;
	localparam int TAIL_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;

	// angle units and radian conversion, 1/128 degree
	localparam longint TURN_FULL    = 46080;
	localparam longint TURN_QUARTER = 11520;
	localparam longint TURN_EIGHTH  = 5760;
	localparam longint unsigned RAD_NUM = 64'd314159265;
	localparam longint unsigned RAD_DEN = 64'd17578125;
	localparam longint unsigned Q30     = 64'd1 << 30;

	localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) << (CW - 1));

	typedef struct packed {
		logic [16:0]   heading;
		logic [19:0]   distance;
		logic [CW-1:0] start_x;
		logic [CW-1:0] start_y;
		logic [CW-1:0] end_x;
		logic [CW-1:0] end_y;
		logic [15:0]   object_tag;
		logic [15:0]   group_tag;
		logic          view_end;
	} seg_req_t;

	typedef struct packed {
		logic [CW-1:0] gsx;
		logic [CW-1:0] gsy;
		logic [CW-1:0] gex;
		logic [CW-1:0] gey;
		logic [15:0]   object_tag;
		logic [15:0]   group_tag;
		logic          view_end;
	} pose_res_t;

	logic clk;
	logic arst_n;

	spt_seg_if  #(.COORD_WIDTH(CW)) seg_ch ();
	spt_pose_if #(.COORD_WIDTH(CW)) pose_ch ();

	segment_pose_transform #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TF)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.local_seg  (seg_ch),
		.global_seg (pose_ch)
	);

	pose_res_t pending_poses[$];
	seg_req_t  dir_req[$];
	pose_res_t dir_want[$];
	bit        dir_lit[$];

	int mismatches  = 0;
	int cycle_count = 0;
	bit no_idle     = 1'b0;
	bit hold_go     = 1'b0;
	bit holding     = 1'b0;

	// sine and cosine of an octant angle, TF fraction bits
	function automatic void octant_sin_cos(input longint unsigned u,
		output longint s, output longint c);
		longint unsigned x, x2, t, k, sh_half;
		int n;
		sh_half = 64'd1 << (30 - TF - 1);
		x  = (u * RAD_NUM * 64'd8192 + RAD_DEN / 2) / RAD_DEN;
		x2 = (x * x + (Q30 >> 1)) >> 30;
		t = Q30;
		for (n = 5; n >= 1; n--) begin
			k = longint'((2 * n) * (2 * n + 1));
			t = Q30 - (x2 * t + (k << 29)) / (k << 30);
		end
		t = (x * t + (Q30 >> 1)) >> 30;
		s = longint'((t + sh_half) >> (30 - TF));
		t = Q30;
		for (n = 6; n >= 1; n--) begin
			k = longint'((2 * n - 1) * (2 * n));
			t = Q30 - (x2 * t + (k << 29)) / (k << 30);
		end
		c = longint'((t + sh_half) >> (30 - TF));
	endfunction

	// reduce the heading to one turn, fold to an octant, unfold by quadrant
	function automatic void heading_sin_cos(input logic [16:0] heading,
		output longint s, output longint c);
		longint a, q, r, s0, c0;
		a = longint'($signed(heading)) % TURN_FULL;
		if (a < 0) begin
			a += TURN_FULL;
		end
		q = a / TURN_QUARTER;
		r = a % TURN_QUARTER;
		if (r <= TURN_EIGHTH) begin
			octant_sin_cos(r, s0, c0);
		end else begin
			octant_sin_cos(TURN_QUARTER - r, c0, s0);
		end
		case (spt_pkg::quad_t'(q[1:0]))
			spt_pkg::QUAD_I: begin
				s = s0; c = c0;
			end
			spt_pkg::QUAD_II: begin
				s = c0; c = -s0;
			end
			spt_pkg::QUAD_III: begin
				s = -s0; c = -c0;
			end
			default: begin
				s = -c0; c = s0;
			end
		endcase
	endfunction

	// round half up to whole millimetres and clamp to the coordinate range
	function automatic logic [CW-1:0] round_to_mm(input longint v);
		longint r;
		r = (v + (longint'(1) << (TF - 1))) >>> TF;
		if (r < COORD_MIN) begin
			r = COORD_MIN;
		end
		if (r > COORD_MAX) begin
			r = COORD_MAX;
		end
		return r[CW-1:0];
	endfunction

	// expected global pose of one local segment
	function automatic pose_res_t transform_segment(input seg_req_t r);
		pose_res_t p;
		longint s, c, d, px, py, sx, sy, ex, ey;
		heading_sin_cos(r.heading, s, c);
		d  = longint'(r.distance);
		sx = longint'($signed(r.start_x));
		sy = longint'($signed(r.start_y));
		ex = longint'($signed(r.end_x));
		ey = longint'($signed(r.end_y));
		px = -(d * s);
		py = d * c;
		p.gsx = round_to_mm(sx * c - sy * s + px);
		p.gsy = round_to_mm(sx * s + sy * c + py);
		p.gex = round_to_mm(ex * c - ey * s + px);
		p.gey = round_to_mm(ex * s + ey * c + py);
		p.object_tag = r.object_tag;
		p.group_tag  = r.group_tag;
		p.view_end   = r.view_end;
		return p;
	endfunction

	function automatic seg_req_t mk_seg(input longint h, input longint d,
		input longint sx, input longint sy, input longint ex, input longint ey,
		input longint ot, input longint gt, input longint ve);
		seg_req_t r;
		r.heading    = h[16:0];
		r.distance   = d[19:0];
		r.start_x    = sx[CW-1:0];
		r.start_y    = sy[CW-1:0];
		r.end_x      = ex[CW-1:0];
		r.end_y      = ey[CW-1:0];
		r.object_tag = ot[15:0];
		r.group_tag  = gt[15:0];
		r.view_end   = ve[0];
		return r;
	endfunction

	function automatic pose_res_t mk_pose(input longint sx, input longint sy,
		input longint ex, input longint ey, input longint ot, input longint gt,
		input longint ve);
		pose_res_t p;
		p.gsx = sx[CW-1:0];
		p.gsy = sy[CW-1:0];
		p.gex = ex[CW-1:0];
		p.gey = ey[CW-1:0];
		p.object_tag = ot[15:0];
		p.group_tag  = gt[15:0];
		p.view_end   = ve[0];
		return p;
	endfunction

	function automatic void add_row(input seg_req_t r, input bit lit, input pose_res_t w);
		dir_req  = {dir_req, r};
		dir_lit  = {dir_lit, lit};
		dir_want = {dir_want, w};
	endfunction

	// extremes, small signed values or full-range noise
	function automatic logic [CW-1:0] rand_coord();
		longint v;
		logic [31:0] w;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = COORD_MIN;
					1: v = COORD_MAX;
					2: v = 0;
					default: v = -1;
				endcase
			end
			1, 2, 3, 4: begin
				w = $urandom();
				v = longint'(w[CW-1:0]);
			end
			default: v = longint'($urandom_range(0, 10000)) - 5000;
		endcase
		return v[CW-1:0];
	endfunction

	function automatic seg_req_t rand_segment();
		seg_req_t r;
		longint h;
		logic [31:0] w;
		case ($urandom_range(0, 7))
			0: begin
				w = $urandom();
				h = longint'(w[16:0]);
			end
			1: h = (longint'($urandom_range(0, 16)) - 8) * TURN_EIGHTH
				+ longint'($urandom_range(0, 4)) - 2;
			default: h = longint'($urandom_range(0, 92160)) - TURN_FULL;
		endcase
		r.heading = h[16:0];
		w = $urandom();
		case ($urandom_range(0, 9))
			0: r.distance = '0;
			1: r.distance = '1;
			2, 3, 4: r.distance = w[19:0];
			default: r.distance = 20'($urandom_range(0, 5000));
		endcase
		r.start_x    = rand_coord();
		r.start_y    = rand_coord();
		r.end_x      = rand_coord();
		r.end_y      = rand_coord();
		w = $urandom();
		r.object_tag = w[15:0];
		r.group_tag  = w[31:16];
		r.view_end   = ($urandom_range(0, 7) == 0);
		return r;
	endfunction

	// offer one request from a falling edge, hold until accepted, log its pose
	task automatic offer(input seg_req_t r, input bit lit, input pose_res_t w);
		pose_res_t want;
		seg_ch.heading     = r.heading;
		seg_ch.distance    = r.distance;
		seg_ch.start_x     = r.start_x;
		seg_ch.start_y     = r.start_y;
		seg_ch.end_x       = r.end_x;
		seg_ch.end_y       = r.end_y;
		seg_ch.object_tag  = r.object_tag;
		seg_ch.group_tag   = r.group_tag;
		seg_ch.view_end_in = r.view_end;
		seg_ch.valid       = 1'b1;
		do begin
			@(posedge clk);
		end while (!seg_ch.ready);
		want = lit ? w : transform_segment(r);
		pending_poses = {pending_poses, want};
		@(negedge clk);
	endtask

	// sender idle burst
	task automatic maybe_gap(input bit gappy);
		if (!no_idle && !holding && gappy && $urandom_range(0, 3) == 0) begin
			seg_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// long receiver hold-off, counted here
	initial begin
		wait (hold_go);
		@(posedge clk);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding = 1'b0;
	end

	// receiver ready with idle bursts and quiet stretches
	initial begin
		int burst;
		int span;
		bit gappy;
		burst = 0;
		span  = 0;
		gappy = 1'b1;
		pose_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (span == 0) begin
				span  = 100;
				gappy = ($urandom_range(0, 2) != 0);
			end
			span--;
			if (holding) begin
				pose_ch.ready = 1'b0;
			end else if (burst > 0) begin
				pose_ch.ready = 1'b0;
				burst--;
			end else if (!no_idle && gappy && $urandom_range(0, 4) == 0) begin
				pose_ch.ready = 1'b0;
				burst = $urandom_range(1, 7) - 1;
			end else begin
				pose_ch.ready = 1'b1;
			end
		end
	end

	// compare each accepted pose with the oldest pending one
	always @(posedge clk) begin
		pose_res_t got;
		pose_res_t want;
		if (arst_n && pose_ch.valid && pose_ch.ready) begin
			got.gsx        = pose_ch.global_start_x;
			got.gsy        = pose_ch.global_start_y;
			got.gex        = pose_ch.global_end_x;
			got.gey        = pose_ch.global_end_y;
			got.object_tag = pose_ch.object_tag_out;
			got.group_tag  = pose_ch.group_tag_out;
			got.view_end   = pose_ch.view_end_out;
			if (pending_poses.size() == 0) begin
				if (mismatches < 10) begin
					$display("extra sx=%0d sy=%0d ex=%0d ey=%0d obj=%h grp=%h end=%b",
						$signed(got.gsx), $signed(got.gsy), $signed(got.gex),
						$signed(got.gey), got.object_tag, got.group_tag, got.view_end);
				end
				mismatches++;
			end else begin
				want = pending_poses.pop_front();
				if (got.gsx !== want.gsx || got.gsy !== want.gsy ||
					got.gex !== want.gex || got.gey !== want.gey ||
					got.object_tag !== want.object_tag ||
					got.group_tag !== want.group_tag ||
					got.view_end !== want.view_end) begin
					if (mismatches < 10) begin
						$display("want sx=%0d sy=%0d ex=%0d ey=%0d obj=%h grp=%h end=%b",
							$signed(want.gsx), $signed(want.gsy), $signed(want.gex),
							$signed(want.gey), want.object_tag, want.group_tag,
							want.view_end);
						$display("got  sx=%0d sy=%0d ex=%0d ey=%0d obj=%h grp=%h end=%b",
							$signed(got.gsx), $signed(got.gsy), $signed(got.gex),
							$signed(got.gey), got.object_tag, got.group_tag, got.view_end);
					end
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int i;
		bit gappy;
		arst_n             = 1'b0;
		seg_ch.valid       = 1'b0;
		seg_ch.heading     = '0;
		seg_ch.distance    = '0;
		seg_ch.start_x     = '0;
		seg_ch.start_y     = '0;
		seg_ch.end_x       = '0;
		seg_ch.end_y       = '0;
		seg_ch.object_tag  = '0;
		seg_ch.group_tag   = '0;
		seg_ch.view_end_in = 1'b0;

		// zero heading: identity rotation, pose is (0, d)
		add_row(mk_seg(0, 0, 100, 200, -300, 400, 0, 0, 0), 1,
			mk_pose(100, 200, -300, 400, 0, 0, 0));
		add_row(mk_seg(0, 1048575, 0, 0, 0, 0, 65535, 65535, 1), 1,
			mk_pose(0, 1048575, 0, 1048575, 65535, 65535, 1));
		add_row(mk_seg(0, 1048575, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1, 2, 0), 1,
			mk_pose(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN + 1048575, 1, 2, 0));
		// half turn negates, most negative x saturates
		add_row(mk_seg(23040, 0, COORD_MIN, COORD_MAX, 5, -7, 3, 4, 1), 1,
			mk_pose(COORD_MAX, -COORD_MAX, -5, 7, 3, 4, 1));
		// quarter turn: (x, y) -> (-y - d, x)
		add_row(mk_seg(11520, 1048575, 3, COORD_MAX, COORD_MIN, COORD_MIN, 5, 6, 0), 1,
			mk_pose(COORD_MIN, 3, -COORD_MIN - 1048575, COORD_MIN, 5, 6, 0));
		// three quarter turn: (x, y) -> (y + d, -x)
		add_row(mk_seg(34560, 1000, 10, 20, COORD_MIN, COORD_MAX, 7, 8, 1), 1,
			mk_pose(1020, -10, COORD_MAX, COORD_MAX, 7, 8, 1));
		// full turns wrap to zero, a negative quarter turn wraps to three quarters
		add_row(mk_seg(46080, 5, 7, 8, 9, 10, 9, 10, 0), 1,
			mk_pose(7, 13, 9, 15, 9, 10, 0));
		add_row(mk_seg(-46080, 0, 7, 8, 9, 10, 11, 12, 1), 1,
			mk_pose(7, 8, 9, 10, 11, 12, 1));
		add_row(mk_seg(-11520, 0, 1, 2, 3, 4, 13, 14, 0), 1,
			mk_pose(2, -1, 4, -3, 13, 14, 0));
		// headings past one turn, octant edges, small angles
		add_row(mk_seg(65535, 1048575, COORD_MAX, COORD_MIN, 1234, -4321, 0, 65535, 1), 0, '0);
		add_row(mk_seg(-65536, 1048575, COORD_MIN, COORD_MAX, -1, 1, 65535, 0, 0), 0, '0);
		add_row(mk_seg(5760, 1000, 1000, 1000, -1000, 1000, 21, 22, 0), 0, '0);
		add_row(mk_seg(5761, 1000, 1000, -1000, 3, 3, 23, 24, 1), 0, '0);
		add_row(mk_seg(5759, 1048575, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 25, 26, 0),
			0, '0);
		add_row(mk_seg(11519, 777, 500, 600, 700, 800, 27, 28, 0), 0, '0);
		add_row(mk_seg(128, 1048575, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 29, 30, 1),
			0, '0);
		add_row(mk_seg(-1, 1, 1, 1, -1, -1, 31, 32, 0), 0, '0);
		add_row(mk_seg(17000, 699050, 24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA,
			16'hAAAA, 16'h5555, 1), 0, '0);
		add_row(mk_seg(40000, 349525, -2, 3, 1, -1, 16'h5555, 16'hAAAA, 1), 0, '0);
		add_row(mk_seg(-23040, 12345, 0, 0, 1, 0, 33, 34, 0), 0, '0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (i = 0; i < dir_req.size(); i++) begin
			maybe_gap(1'b1);
			offer(dir_req[i], dir_lit[i], dir_want[i]);
		end

		// random segments, with a receiver hold-off, a full drain and a quiet tail
		gappy = 1'b1;
		for (i = 0; i < N_RANDOM; i++) begin
			if (i % 40 == 0) begin
				gappy = ($urandom_range(0, 2) != 0);
			end
			if (i == HOLD_AT) begin
				hold_go = 1'b1;
			end
			if (i == DRAIN_AT) begin
				seg_ch.valid = 1'b0;
				while (pending_poses.size() != 0) @(negedge clk);
			end
			if (i == N_RANDOM - QUIET_TAIL) begin
				no_idle = 1'b1;
			end
			maybe_gap(gappy);
			offer(rand_segment(), 1'b0, '0);
		end
		seg_ch.valid = 1'b0;

		while (pending_poses.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
